// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ID_W  = 16;
    localparam int PRI_W = 8;
    localparam int OP_W  = 2;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } spq_op_t;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } spq_entry_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             pop;
        logic             del;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } spq_bcast_t;

endpackage

// File: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares against the broadcast request and
// takes data from itself, its upper neighbor, its lower neighbor or the bus.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX   = 0,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  spq_bcast_t       bcast,
    input  logic [CNT_W-1:0] count,
    input  logic [CNT_W-1:0] scan,
    input  logic             prev_ahead,
    input  spq_entry_t       prev_entry,
    input  spq_entry_t       next_entry,
    output spq_entry_t       entry,
    output logic             ahead,
    output logic             match
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;
    logic       occupied;

    always_comb
    begin
        occupied = MY_IDX < count;
        // new item lands ahead of this slot (empty slots count as lowest)
        ahead    = !occupied || (entry_reg.pri <= bcast.pri);
        match    = occupied && (entry_reg.id == bcast.id);

        entry_next = entry_reg;
        priority if (bcast.ins)
        begin
            if (prev_ahead)
            begin
                entry_next = prev_entry;
            end
            else if (ahead)
            begin
                entry_next.id  = bcast.id;
                entry_next.pri = bcast.pri;
            end
        end
        else if (bcast.pop)
        begin
            entry_next = next_entry;
        end
        else if (bcast.del && (MY_IDX >= scan))
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: src/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Priority queue of (id, priority) pairs kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries operation, req_id and
// priority_req; output channel out_valid/out_ready carries result_id,
// result_priority and status, one result per input transfer, in order.
// Insert and pop: the result is registered and shows in the cycle after
// the transfer, and a new item is taken every cycle as long as the
// output register is free or being drained. The unused operation
// code behaves the same and returns ok.
// Remove walks a scan index down the chain one cell per cycle; a match
// ends the scan at its slot, a miss when the index reaches count.
// No input is taken during the scan.
// When out_ready is low with a result held, in_ready drops and a scan
// that has found its answer waits; nothing is lost or reordered.
// Reset empties the queue at once (count cleared, no clearing pass) and
// drops any held result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   operation,
    input  logic [ID_W-1:0]   req_id,
    input  logic [PRI_W-1:0]  priority_req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ID_W-1:0]   result_id,
    output logic [PRI_W-1:0]  result_priority,
    output logic [STAT_W-1:0] status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [ID_W-1:0]   key_reg, key_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [PRI_W-1:0]  res_pri_reg, res_pri_next;
    logic [STAT_W-1:0] status_reg, status_next;

    spq_bcast_t        bcast;
    spq_entry_t        entry [DEPTH];
    logic [DEPTH-1:0]  ahead;
    logic [DEPTH-1:0]  match;

    logic              out_free;
    logic              accept;
    logic              full;
    logic              empty;
    logic              scan_end;
    logic              scan_hit;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign full     = count_reg == FULL_CNT;
    assign empty    = count_reg == '0;
    assign scan_end = scan_reg == count_reg;
    assign scan_hit = !scan_end && match[scan_reg[IDX_W-1:0]];

    always_comb
    begin
        bcast.ins = accept && (operation == OP_INSERT) && !full;
        bcast.pop = accept && (operation == OP_POP) && !empty;
        bcast.del = (state_reg == ST_SCAN) && scan_hit && out_free;
        bcast.id  = (state_reg == ST_SCAN) ? key_reg : req_id;
        bcast.pri = priority_req;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_entry_t prev_e;
        spq_entry_t next_e;
        logic       prev_b;

        if (i == 0)
        begin : g_head
            assign prev_e = '0;
            assign prev_b = 1'b0;
        end
        else
        begin : g_body
            assign prev_e = entry[i-1];
            assign prev_b = ahead[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_e = '0;
        end
        else
        begin : g_link
            assign next_e = entry[i+1];
        end

        spq_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk         (clk),
            .bcast       (bcast),
            .count       (count_reg),
            .scan        (scan_reg),
            .prev_ahead  (prev_b),
            .prev_entry  (prev_e),
            .next_entry  (next_e),
            .entry       (entry[i]),
            .ahead       (ahead[i]),
            .match       (match[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_id_next    = res_id_reg;
        res_pri_next   = res_pri_reg;
        status_next    = status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_id_next  = '0;
                    res_pri_next = '0;
                    status_next  = STAT_OK;
                    unique case (operation)
                        OP_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            out_valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                res_id_next  = entry[0].id;
                                res_pri_next = entry[0].pri;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            state_next = ST_SCAN;
                            scan_next  = '0;
                            key_next   = req_id;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_end || scan_hit)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        res_id_next    = '0;
                        res_pri_next   = '0;
                        state_next     = ST_IDLE;
                        if (scan_hit)
                        begin
                            status_next = STAT_OK;
                            count_next  = count_reg - 1'b1;
                        end
                        else
                        begin
                            status_next = STAT_NOTFOUND;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        res_id_reg  <= res_id_next;
        res_pri_reg <= res_pri_next;
        status_reg  <= status_next;
    end

    assign out_valid       = out_valid_reg;
    assign result_id       = res_id_reg;
    assign result_priority = res_pri_reg;
    assign status          = status_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_scan_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_reg <= count_reg))
        else $error("scan index ran past the stored entries");

    a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_INSERT) && full)
        |=> (out_valid_reg && (status_reg == STAT_FULL) && (count_reg == FULL_CNT)))
        else $error("insert on full queue not dropped");

    a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_POP) && !empty)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not shrink the queue");

    a_scan_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !in_ready)
        else $error("input taken during remove scan");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_priority_queue_top.
// A directed table walks the corner cases (empty pop, missed remove, ties,
// full queue, long remove scans), then random fill/drain/mixed bursts run
// under three idling mixes. Every result is checked against a local model
// of the sorted queue, in order.
// ----------------------------------------------------------------------------
module tb
    import spq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;   // longest remove scan, plus slack
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic [STAT_W-1:0] st;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        int               rep;
        bit               typed;
        result_t          res;
    } step_t;

    // rows with typed=1 carry the expected result; the rest use the model
    localparam step_t DIRECTED [22] = '{
        '{OP_POP,    16'h0000, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_EMPTY}},
        '{OP_REMOVE, 16'h0000, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_NOTFOUND}},
        '{OP_UNUSED, 16'hFFFF, 8'hFF,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_INSERT, 16'hFFFF, 8'hFF,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_INSERT, 16'h0000, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_INSERT, 16'h1234, 8'hFF,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_INSERT, 16'h0000, 8'h7F,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_REMOVE, 16'h0000, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_POP,    16'h0000, 8'h00,  1, 1'b1, '{16'h1234, 8'hFF, STAT_OK}},
        '{OP_POP,    16'h0000, 8'h00,  1, 1'b1, '{16'hFFFF, 8'hFF, STAT_OK}},
        '{OP_POP,    16'h0000, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_POP,    16'h0000, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_EMPTY}},
        '{OP_INSERT, 16'h0100, 8'h80, 16, 1'b0, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_INSERT, 16'hBEEF, 8'hFF,  1, 1'b1, '{16'h0000, 8'h00, STAT_FULL}},
        '{OP_REMOVE, 16'h0100, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_REMOVE, 16'h010F, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_REMOVE, 16'hDEAD, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_NOTFOUND}},
        '{OP_INSERT, 16'h5555, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_INSERT, 16'hAAAA, 8'hFF,  1, 1'b1, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_POP,    16'h0000, 8'h00,  1, 1'b1, '{16'hAAAA, 8'hFF, STAT_OK}},
        '{OP_POP,    16'h0000, 8'h00, 15, 1'b0, '{16'h0000, 8'h00, STAT_OK}},
        '{OP_POP,    16'h0000, 8'h00,  1, 1'b1, '{16'h0000, 8'h00, STAT_EMPTY}}
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   req_id;
    logic [PRI_W-1:0]  priority_req;
    logic              out_valid;
    logic              out_ready;
    logic [ID_W-1:0]   result_id;
    logic [PRI_W-1:0]  result_priority;
    logic [STAT_W-1:0] status;

    // local copy of the queue, head at slot 0
    logic [ID_W-1:0]  queue_id  [DEPTH];
    logic [PRI_W-1:0] queue_pri [DEPTH];
    int               queue_len;

    result_t pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off;
    int n_errors;
    int n_checked;
    int n_sent [4];
    int n_full;
    int n_empty;
    int n_notfound;

    sorted_priority_queue_top #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .req_id          (req_id),
        .priority_req    (priority_req),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_id       (result_id),
        .result_priority (result_priority),
        .status          (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("tb: ERROR at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    function automatic void take_out(input int pos);
        for (int i = pos; i + 1 < queue_len; i++)
        begin
            queue_id[i]  = queue_id[i + 1];
            queue_pri[i] = queue_pri[i + 1];
        end
        queue_len--;
    endfunction

    // updates the local queue and returns the result the block must give
    function automatic result_t apply_request(input logic [OP_W-1:0] op,
                                              input logic [ID_W-1:0] id,
                                              input logic [PRI_W-1:0] pri);
        result_t r;
        int      pos;
        r = '0;
        r.st = STAT_OK;
        case (op)
            OP_INSERT:
            begin
                if (queue_len >= DEPTH)
                    r.st = STAT_FULL;
                else
                begin
                    // goes ahead of equal priorities: newest first among ties
                    pos = 0;
                    while (pos < queue_len && queue_pri[pos] > pri)
                        pos++;
                    for (int i = queue_len; i > pos; i--)
                    begin
                        queue_id[i]  = queue_id[i - 1];
                        queue_pri[i] = queue_pri[i - 1];
                    end
                    queue_id[pos]  = id;
                    queue_pri[pos] = pri;
                    queue_len++;
                end
            end
            OP_POP:
            begin
                if (queue_len == 0)
                    r.st = STAT_EMPTY;
                else
                begin
                    r.id  = queue_id[0];
                    r.pri = queue_pri[0];
                    take_out(0);
                end
            end
            OP_REMOVE:
            begin
                pos = 0;
                while (pos < queue_len && queue_id[pos] != id)
                    pos++;
                if (pos < queue_len)
                    take_out(pos);
                else
                    r.st = STAT_NOTFOUND;
            end
            default:
                ;
        endcase
        case (r.st)
            STAT_FULL:     n_full++;
            STAT_EMPTY:    n_empty++;
            STAT_NOTFOUND: n_notfound++;
            default:       ;
        endcase
        return r;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [PRI_W-1:0] pri, input bit typed = 1'b0,
                             input result_t typed_res = '0);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid     <= 1'b0;
            operation    <= OP_W'($urandom);
            req_id       <= ID_W'($urandom);
            priority_req <= PRI_W'($urandom);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        operation    <= op;
        req_id       <= id;
        priority_req <= pri;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predicted = apply_request(op, id, pri);
        pending_results.push_back(typed ? typed_res : predicted);
        n_sent[op]++;
    endtask

    // sender holds off until every result is back and the block has settled
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return ID_W'($urandom_range(7));    // small pool: duplicate ids
        else if (r < 35)
            return '0;
        else if (r < 40)
            return '1;
        return ID_W'($urandom);
    endfunction

    function automatic logic [PRI_W-1:0] pick_pri();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return PRI_W'($urandom_range(3));   // lots of ties
        else if (r < 40)
            return '1;
        else if (r < 50)
            return '0;
        return PRI_W'($urandom);
    endfunction

    task automatic send_mixed();
        int r;
        logic [ID_W-1:0] id;
        r = $urandom_range(99);
        if (r < 45)
            send_item(OP_INSERT, pick_id(), pick_pri());
        else if (r < 72)
            send_item(OP_POP, ID_W'($urandom), PRI_W'($urandom));
        else if (r < 97)
        begin
            if (queue_len > 0 && $urandom_range(99) < 70)
                id = queue_id[$urandom_range(queue_len - 1)];
            else
                id = pick_id();
            send_item(OP_REMOVE, id, PRI_W'($urandom));
        end
        else
            send_item(OP_UNUSED, ID_W'($urandom), PRI_W'($urandom));
    endtask

    task automatic run_random(input int n_items);
        int sent;
        int kind;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(9);
            if (kind < 2)
            begin
                // fill up, then knock on the full queue
                while (queue_len < DEPTH)
                begin
                    send_item(OP_INSERT, pick_id(), pick_pri());
                    sent++;
                end
                repeat ($urandom_range(1, 3))
                begin
                    send_item(OP_INSERT, pick_id(), pick_pri());
                    sent++;
                end
            end
            else if (kind < 4)
            begin
                while (queue_len > 0)
                begin
                    send_item(OP_POP, ID_W'($urandom), PRI_W'($urandom));
                    sent++;
                end
                repeat ($urandom_range(1, 2))
                begin
                    send_item(OP_POP, ID_W'($urandom), PRI_W'($urandom));
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(5, 25))
                begin
                    send_mixed();
                    sent++;
                end
            end
        end
    endtask

    // receiver: random stalls, or a counted hold-off when asked
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                hold_off--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            n_checked++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, status", int'(status), 0);
            else
            begin
                want = pending_results.pop_front();
                if (result_id !== want.id)
                    report_mismatch("result_id", int'(result_id), int'(want.id));
                if (result_priority !== want.pri)
                    report_mismatch("result_priority", int'(result_priority),
                                    int'(want.pri));
                if (status !== want.st)
                    report_mismatch("status", int'(status), int'(want.st));
            end
        end
    end

    initial
    begin
        #5ms;
        $display("tb: timeout with %0d results outstanding", pending_results.size());
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = '0;
        req_id       = '0;
        priority_req = '0;
        queue_len    = 0;
        hold_off     = 0;
        n_errors     = 0;
        n_checked    = 0;
        n_full       = 0;
        n_empty      = 0;
        n_notfound   = 0;
        n_sent       = '{default: 0};
        foreach (queue_id[i])
        begin
            queue_id[i]  = '0;
            queue_pri[i] = '0;
        end
        send_idle_pct = 32;
        recv_idle_pct = 58;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[r])
            for (int k = 0; k < DIRECTED[r].rep; k++)
                send_item(DIRECTED[r].op, ID_W'(DIRECTED[r].id + k), DIRECTED[r].pri,
                          DIRECTED[r].typed, DIRECTED[r].res);
        wait_idle();

        run_random(RANDOM_PER_PHASE);
        wait_idle();

        send_idle_pct = 58;
        recv_idle_pct = 32;
        run_random(RANDOM_PER_PHASE);
        wait_idle();

        // no idling; open with a long output stall so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 150;
        run_random(RANDOM_PER_PHASE);
        wait_idle();

        if (pending_results.size() != 0)
            report_mismatch("results never returned, count", pending_results.size(), 0);
        $display("tb: %0d transfers in: %0d insert, %0d pop, %0d remove, %0d unused code",
                 n_sent[OP_INSERT] + n_sent[OP_POP] + n_sent[OP_REMOVE]
                 + n_sent[OP_UNUSED],
                 n_sent[OP_INSERT], n_sent[OP_POP], n_sent[OP_REMOVE], n_sent[OP_UNUSED]);
        $display("tb: %0d results checked; %0d full, %0d empty, %0d not found; %0d errors",
                 n_checked, n_full, n_empty, n_notfound, n_errors);
        if (n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
